### rtl/jump_beat_tracker_macros.svh
`ifndef JUMP_BEAT_TRACKER_MACROS_SVH
`define JUMP_BEAT_TRACKER_MACROS_SVH

// same-cycle implication on clk, held off during reset
`define JBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jump_beat_tracker assertion failed");

// next-cycle implication on clk, held off during reset
`define JBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jump_beat_tracker assertion failed");

`endif

### rtl/jbt_pkg.sv
package jbt_pkg;

    localparam int DEFAULT_HISTORY_DEPTH = 3;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int BPM_Q8_NUMERATOR = 15360000;

    localparam logic [15:0] AIR_THRESHOLD_RST = 16'd819;
    localparam logic [7:0]  CONFIRM_COUNT_RST = 8'd2;
    localparam logic [15:0] BEAT_LEAD_RST     = 16'd150;
    localparam logic [15:0] REGULAR_WINDOW_RST = 16'd1500;
    localparam logic [7:0]  RUN_MAX = 8'd255;
    localparam logic [15:0] BPM_SAT = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_AIR_THRESHOLD  = 2'd0,
        REG_CONFIRM_COUNT  = 2'd1,
        REG_BEAT_LEAD      = 2'd2,
        REG_REGULAR_WINDOW = 2'd3
    } jbt_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } jbt_div_status_t;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == RUN_MAX) ? v : v + 8'd1;
    endfunction

endpackage

### rtl/jbt_div.sv
module jbt_div #(
    parameter int DIVIDEND_W = 35
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DIVIDEND_W-1:0]       dividend,
    input  logic [31:0]                 divisor,
    output logic [DIVIDEND_W-1:0]       quotient,
    output jbt_pkg::jbt_div_status_t    status
);
    import jbt_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [31:0]           rem_reg, rem_next;
    logic [31:0]           divisor_reg, divisor_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [32:0]           trial;
    logic [32:0]           diff;
    logic                  ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        ge    = (trial >= {1'b0, divisor_reg});

        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        quo_next     = quo_reg;

        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = CNT_W'(DIVIDEND_W);
            rem_next     = 32'd0;
            divisor_next = divisor;
            quo_next     = dividend;
        end
        else if (busy_reg)
        begin
            rem_next   = ge ? diff[31:0] : trial[31:0];
            quo_next   = {quo_reg[DIVIDEND_W-2:0], ge};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        quo_reg     <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### rtl/jump_beat_tracker.sv
// jump beat tracker
// sample channel: sample_valid/sample_stall carry one beat of magnitude (signed
// Q3.12) and now_ms. result channel: result_valid/result_stall carry one beat
// per sample with the airborne state, start/middle/end/beat pulses, the strong
// flag, the average jump interval and the bpm in Q8.8.
// a sample with no confirmed jump start goes from S_STEP straight to S_BEAT,
// where its result is registered; no new sample is taken before the block is
// back in S_IDLE. a sample that confirms a start is pushed into the history,
// which is then summed one entry per cycle; the shared bit-serial divider
// (SUM_W bits, 35 at depth 3) then runs once for the mean and once for the
// bpm, the bpm division being skipped when the mean is zero or less, which
// saturates the bpm.
// sample_stall is high while a sample is being worked on.
// if result_stall holds a result, the next sample is still accepted and worked
// on; it waits in its last step until the result register frees up.
// configuration is to be written through the apb port while the block is idle;
// the block does not enforce this. reset restores the register defaults, clears
// tracking state, saturates bpm, one zero interval in history; no clearing pass.
module jump_beat_tracker #(
    parameter int HISTORY_DEPTH = jbt_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [jbt_pkg::ADDR_W-1:0]   paddr,
    input  logic [jbt_pkg::DATA_W-1:0]   pwdata,
    output logic [jbt_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic signed [15:0]           magnitude,
    input  logic [31:0]                  now_ms,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic                         airborne,
    output logic                         start_pulse,
    output logic                         middle_pulse,
    output logic                         end_pulse,
    output logic                         beat_pulse,
    output logic                         strong_beat,
    output logic signed [31:0]           avg_interval_ms,
    output logic [15:0]                  bpm_q8
);
    import jbt_pkg::*;

    `include "jump_beat_tracker_macros.svh"

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = 32 + $clog2(HISTORY_DEPTH) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_SUM,
        S_DIV_AVG,
        S_WAIT_AVG,
        S_DIV_BPM,
        S_WAIT_BPM,
        S_BEAT
    } state_t;

    // configuration registers
    logic [15:0] air_threshold_reg;
    logic [7:0]  confirm_count_reg;
    logic [15:0] beat_lead_reg;
    logic [15:0] regular_window_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_threshold_reg  <= AIR_THRESHOLD_RST;
            confirm_count_reg  <= CONFIRM_COUNT_RST;
            beat_lead_reg      <= BEAT_LEAD_RST;
            regular_window_reg <= REGULAR_WINDOW_RST;
        end
        else if (cfg_write)
        begin
            case (jbt_reg_t'(paddr[3:2]))
                REG_AIR_THRESHOLD:  air_threshold_reg  <= pwdata[15:0];
                REG_CONFIRM_COUNT:  confirm_count_reg  <= pwdata[7:0];
                REG_BEAT_LEAD:      beat_lead_reg      <= pwdata[15:0];
                REG_REGULAR_WINDOW: regular_window_reg <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (jbt_reg_t'(paddr[3:2]))
            REG_AIR_THRESHOLD:  prdata = {{16{air_threshold_reg[15]}}, air_threshold_reg};
            REG_CONFIRM_COUNT:  prdata = {24'd0, confirm_count_reg};
            REG_BEAT_LEAD:      prdata = {16'd0, beat_lead_reg};
            REG_REGULAR_WINDOW: prdata = {16'd0, regular_window_reg};
            default:            prdata = '0;
        endcase
    end

    // tracking state
    state_t            state_reg, state_next;
    logic [15:0]       mag_reg, mag_next;
    logic [31:0]       now_reg, now_next;
    logic              airborne_reg, airborne_next;
    logic [7:0]        high_run_reg, high_run_next;
    logic [7:0]        low_run_reg, low_run_next;
    logic [31:0]       first_high_reg, first_high_next;
    logic [31:0]       first_low_reg, first_low_next;
    logic [31:0]       jump_start_reg, jump_start_next;
    logic [31:0]       air_dur_reg, air_dur_next;
    logic [31:0]       cur_int_reg, cur_int_next;
    logic [31:0]       hist_reg [HISTORY_DEPTH];
    logic [31:0]       hist_next [HISTORY_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       last_beat_reg, last_beat_next;
    logic              start_done_reg, start_done_next;
    logic              end_done_reg, end_done_next;
    logic              middle_done_reg, middle_done_next;
    logic              beat_done_reg, beat_done_next;
    logic              strong_reg, strong_next;
    logic [31:0]       avg_reg, avg_next;
    logic [15:0]       bpm_reg, bpm_next;
    logic              start_p_reg, start_p_next;
    logic              mid_p_reg, mid_p_next;
    logic              end_p_reg, end_p_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    // result register
    logic              res_valid_reg, res_valid_next;
    logic              res_airborne_reg, res_airborne_next;
    logic              res_start_reg, res_start_next;
    logic              res_mid_reg, res_mid_next;
    logic              res_end_reg, res_end_next;
    logic              res_beat_reg, res_beat_next;
    logic              res_strong_reg, res_strong_next;
    logic [31:0]       res_avg_reg, res_avg_next;
    logic [15:0]       res_bpm_reg, res_bpm_next;

    // per-sample update terms
    logic              is_high;
    logic [7:0]        hr_step, lr_step;
    logic [31:0]       fh_step, fl_step;
    logic [31:0]       gap;
    logic              long_ago;
    logic              go_high, go_low;
    logic              new_start, new_end;
    logic [31:0]       cur_int_step, jump_start_step, air_dur_step;
    logic              airborne_step;
    logic [31:0]       air_round;
    logic [31:0]       half;
    logic [31:0]       mid_diff;
    logic              mid_hit;

    // shared divider
    logic                    div_start;
    logic [SUM_W-1:0]        div_dividend;
    logic [31:0]             div_divisor;
    logic [SUM_W-1:0]        div_quotient;
    jbt_div_status_t         div_status;
    logic [SUM_W-1:0]        abs_sum;
    logic [31:0]             avg_calc;
    logic [31:0]             next_beat;
    logic [31:0]             beat_diff;
    logic                    beat_hit;

    assign sample_stall = (state_reg != S_IDLE);

    always_comb
    begin
        is_high = $signed(mag_reg) > $signed(air_threshold_reg);
        hr_step = is_high ? sat_inc8(high_run_reg) : 8'd0;
        lr_step = is_high ? 8'd0 : sat_inc8(low_run_reg);
        fh_step = (is_high && high_run_reg == 8'd0) ? now_reg : first_high_reg;
        fl_step = (!is_high && low_run_reg == 8'd1) ? now_reg : first_low_reg;

        gap      = now_reg - last_beat_reg;
        long_ago = $signed(gap) > $signed({16'd0, regular_window_reg});

        go_high   = (hr_step >= confirm_count_reg);
        go_low    = !go_high && (lr_step >= confirm_count_reg);
        new_start = go_high && !start_done_reg;
        new_end   = go_low && !end_done_reg;

        cur_int_step    = (new_start && !long_ago) ? (now_reg - jump_start_reg) : cur_int_reg;
        jump_start_step = new_start ? fh_step : jump_start_reg;
        air_dur_step    = new_end ? (fl_step - jump_start_reg) : air_dur_reg;
        airborne_step   = go_high ? 1'b1 : (go_low ? 1'b0 : airborne_reg);

        // signed halving, truncated toward zero
        air_round = air_dur_step + {31'd0, air_dur_step[31]};
        half      = {air_round[31], air_round[31:1]};
        mid_diff  = now_reg - (jump_start_step + half);
        mid_hit   = airborne_step && !mid_diff[31] && !middle_done_reg;
    end

    always_comb
    begin
        abs_sum   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        avg_calc  = sum_reg[SUM_W-1] ? (~div_quotient[31:0] + 32'd1) : div_quotient[31:0];
        next_beat = jump_start_reg + avg_reg - {16'd0, beat_lead_reg};
        beat_diff = now_reg - next_beat;
        beat_hit  = !beat_diff[31] && !beat_done_reg;

        div_start    = (state_reg == S_DIV_AVG) || (state_reg == S_DIV_BPM);
        div_dividend = (state_reg == S_DIV_AVG) ? abs_sum : SUM_W'(BPM_Q8_NUMERATOR);
        div_divisor  = (state_reg == S_DIV_AVG) ? 32'(count_reg) : avg_reg;
    end

    jbt_div #(
        .DIVIDEND_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_comb
    begin
        state_next        = state_reg;
        mag_next          = mag_reg;
        now_next          = now_reg;
        airborne_next     = airborne_reg;
        high_run_next     = high_run_reg;
        low_run_next      = low_run_reg;
        first_high_next   = first_high_reg;
        first_low_next    = first_low_reg;
        jump_start_next   = jump_start_reg;
        air_dur_next      = air_dur_reg;
        cur_int_next      = cur_int_reg;
        hist_next         = hist_reg;
        count_next        = count_reg;
        last_beat_next    = last_beat_reg;
        start_done_next   = start_done_reg;
        end_done_next     = end_done_reg;
        middle_done_next  = middle_done_reg;
        beat_done_next    = beat_done_reg;
        strong_next       = strong_reg;
        avg_next          = avg_reg;
        bpm_next          = bpm_reg;
        start_p_next      = start_p_reg;
        mid_p_next        = mid_p_reg;
        end_p_next        = end_p_reg;
        sum_next          = sum_reg;
        idx_next          = idx_reg;
        res_valid_next    = res_valid_reg && result_stall;
        res_airborne_next = res_airborne_reg;
        res_start_next    = res_start_reg;
        res_mid_next      = res_mid_reg;
        res_end_next      = res_end_reg;
        res_beat_next     = res_beat_reg;
        res_strong_next   = res_strong_reg;
        res_avg_next      = res_avg_reg;
        res_bpm_next      = res_bpm_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    mag_next   = magnitude;
                    now_next   = now_ms;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                high_run_next    = hr_step;
                low_run_next     = lr_step;
                first_high_next  = fh_step;
                first_low_next   = fl_step;
                cur_int_next     = cur_int_step;
                jump_start_next  = jump_start_step;
                air_dur_next     = air_dur_step;
                airborne_next    = airborne_step;
                start_done_next  = go_high ? 1'b1 : (go_low ? 1'b0 : start_done_reg);
                end_done_next    = go_high ? 1'b0 : (go_low ? 1'b1 : end_done_reg);
                middle_done_next = airborne_step && (middle_done_reg || mid_hit);
                beat_done_next   = new_start ? 1'b0 : beat_done_reg;
                start_p_next     = new_start;
                mid_p_next       = mid_hit;
                end_p_next       = new_end;
                if (new_start)
                begin
                    // push the interval, dropping the oldest when full
                    for (int i = 0; i < HISTORY_DEPTH; i++)
                    begin
                        if (count_reg < CNT_W'(HISTORY_DEPTH))
                        begin
                            if (CNT_W'(i) == count_reg)
                            begin
                                hist_next[i] = cur_int_step;
                            end
                        end
                        else if (i == HISTORY_DEPTH - 1)
                        begin
                            hist_next[i] = cur_int_step;
                        end
                        else
                        begin
                            hist_next[i] = hist_reg[(i + 1) % HISTORY_DEPTH];
                        end
                    end
                    if (count_reg < CNT_W'(HISTORY_DEPTH))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    sum_next   = '0;
                    idx_next   = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_BEAT;
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg + SUM_W'($signed(hist_reg[idx_reg[IDX_W-1:0]]));
                idx_next = idx_reg + 1'b1;
                if (CNT_W'(idx_reg + 1'b1) == count_reg)
                begin
                    state_next = S_DIV_AVG;
                end
            end
            S_DIV_AVG:
            begin
                state_next = S_WAIT_AVG;
            end
            S_WAIT_AVG:
            begin
                if (div_status.done)
                begin
                    avg_next = avg_calc;
                    if ($signed(avg_calc) <= 0)
                    begin
                        bpm_next   = BPM_SAT;
                        state_next = S_BEAT;
                    end
                    else
                    begin
                        state_next = S_DIV_BPM;
                    end
                end
            end
            S_DIV_BPM:
            begin
                state_next = S_WAIT_BPM;
            end
            S_WAIT_BPM:
            begin
                if (div_status.done)
                begin
                    bpm_next   = (|div_quotient[SUM_W-1:16]) ? BPM_SAT : div_quotient[15:0];
                    state_next = S_BEAT;
                end
            end
            S_BEAT:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    if (beat_hit)
                    begin
                        beat_done_next = 1'b1;
                        strong_next    = !strong_reg;
                        last_beat_next = next_beat;
                    end
                    res_valid_next    = 1'b1;
                    res_airborne_next = airborne_reg;
                    res_start_next    = start_p_reg;
                    res_mid_next      = mid_p_reg;
                    res_end_next      = end_p_reg;
                    res_beat_next     = beat_hit;
                    res_strong_next   = beat_hit ? !strong_reg : strong_reg;
                    res_avg_next      = avg_reg;
                    res_bpm_next      = bpm_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            airborne_reg    <= 1'b0;
            high_run_reg    <= 8'd0;
            low_run_reg     <= 8'd0;
            first_high_reg  <= 32'd0;
            first_low_reg   <= 32'd0;
            jump_start_reg  <= 32'd0;
            air_dur_reg     <= 32'd0;
            cur_int_reg     <= 32'd0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= 32'd0;
            end
            count_reg       <= CNT_W'(1);
            last_beat_reg   <= 32'd0;
            start_done_reg  <= 1'b0;
            end_done_reg    <= 1'b0;
            middle_done_reg <= 1'b0;
            beat_done_reg   <= 1'b0;
            strong_reg      <= 1'b0;
            avg_reg         <= 32'd0;
            bpm_reg         <= BPM_SAT;
            start_p_reg     <= 1'b0;
            mid_p_reg       <= 1'b0;
            end_p_reg       <= 1'b0;
            idx_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            airborne_reg    <= airborne_next;
            high_run_reg    <= high_run_next;
            low_run_reg     <= low_run_next;
            first_high_reg  <= first_high_next;
            first_low_reg   <= first_low_next;
            jump_start_reg  <= jump_start_next;
            air_dur_reg     <= air_dur_next;
            cur_int_reg     <= cur_int_next;
            hist_reg        <= hist_next;
            count_reg       <= count_next;
            last_beat_reg   <= last_beat_next;
            start_done_reg  <= start_done_next;
            end_done_reg    <= end_done_next;
            middle_done_reg <= middle_done_next;
            beat_done_reg   <= beat_done_next;
            strong_reg      <= strong_next;
            avg_reg         <= avg_next;
            bpm_reg         <= bpm_next;
            start_p_reg     <= start_p_next;
            mid_p_reg       <= mid_p_next;
            end_p_reg       <= end_p_next;
            idx_reg         <= idx_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg          <= mag_next;
        now_reg          <= now_next;
        sum_reg          <= sum_next;
        res_airborne_reg <= res_airborne_next;
        res_start_reg    <= res_start_next;
        res_mid_reg      <= res_mid_next;
        res_end_reg      <= res_end_next;
        res_beat_reg     <= res_beat_next;
        res_strong_reg   <= res_strong_next;
        res_avg_reg      <= res_avg_next;
        res_bpm_reg      <= res_bpm_next;
    end

    assign result_valid    = res_valid_reg;
    assign airborne        = res_airborne_reg;
    assign start_pulse     = res_start_reg;
    assign middle_pulse    = res_mid_reg;
    assign end_pulse       = res_end_reg;
    assign beat_pulse      = res_beat_reg;
    assign strong_beat     = res_strong_reg;
    assign avg_interval_ms = res_avg_reg;
    assign bpm_q8          = res_bpm_reg;

    `JBT_ASSERT_NXT(a_accept_to_step, sample_valid && !sample_stall, state_reg == S_STEP)
    `JBT_ASSERT_IMP(a_start_end_apart, result_valid, !(start_pulse && end_pulse))
    `JBT_ASSERT_IMP(a_mid_in_air, result_valid && middle_pulse, airborne)
    `JBT_ASSERT_IMP(a_count_range, 1'b1, count_reg >= CNT_W'(1) && count_reg <= CNT_W'(HISTORY_DEPTH))
    `JBT_ASSERT_IMP(a_div_done_waited, div_status.done, state_reg == S_WAIT_AVG || state_reg == S_WAIT_BPM)
    `JBT_ASSERT_IMP(a_div_start_idle, div_start, !div_status.busy)

endmodule
